[sv/tlct_pkg.sv]
// Shared types and constants for the tile LRU tag store.
// Used by tlct_front, tlct_back and the top level tile_lru_cache_tags.
`default_nettype none

package tlct_pkg;

    // default sizes
    localparam int ENTRIES_DEF    = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 32;

    // fixed port field widths
    localparam int KEY_W     = 16;
    localparam int FSTAMP_W  = 32;
    localparam int SLOT_W    = 4;
    localparam int KIND_W    = 3;
    localparam int CAP_BITS  = 5;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // front queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT   = 3'd0,
        KIND_FILL  = 3'd1,
        KIND_MISS  = 3'd2,
        KIND_EVICT = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EVICT,
        ST_FILL
    } st_t;

    // command word handed from front to back
    typedef struct packed {
        op_t                 op;
        logic [KEY_W-1:0]    col;
        logic [KEY_W-1:0]    row;
        logic [FSTAMP_W-1:0] stamp;
        logic                loadable;
    } cmd_t;

    // result word
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  col;
        logic [KEY_W-1:0]  row;
        logic              last;
    } res_t;

endpackage

`default_nettype wire

[sv/tile_lru_cache_tags.sv]
// Tile LRU tag store, top level: capacity register, front queue, back end.
// Depends on tlct_pkg, tlct_front and tlct_back.
//
// Use: each slave word is a lookup (tuser 0) or a clear (tuser 1). A lookup
// returns a hit, a fill or a not-stored miss; a fill that finds the store at
// capacity first reports one evict word per entry it throws out (oldest
// stamp, lowest slot on ties). tlast marks the final word of each request.
// Each word passes the command queue, command register and output register.
// Hits, misses, clears and fills into a free slot run at one word per cycle
// while the master side is ready. Each eviction first sweeps the stamp
// memory for the oldest entry, one per cycle. The user must write capacity
// through cfg_we / cfg_wdata only while idle; the block does not check it.
// Reset empties the store at once (valid bits cleared) and sets capacity to
// 16. A stalled master side holds its word in the output register; the back
// end waits, the two-word command queue fills and s_tready falls.
`default_nettype none

module tile_lru_cache_tags
    import tlct_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // tile_col, tile_row, frame_stamp, loadable, pad
    input  logic                 s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // slot, key_col, key_row, pad
    output logic [KIND_W-1:0]    m_tuser,   // kind
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CAP_BITS-1:0]  cfg_wdata
);

    logic [CAP_BITS-1:0] capacity_reg;
    logic                q_valid;
    logic                q_ready;
    cmd_t                q_cmd;
    res_t                res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    tlct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    tlct_back #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'b0000, res.row, res.col, res.slot};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

`ifndef SYNTHESIS
    // back end only pops a queue that holds a command
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> q_valid)
        else $error("command popped from empty queue");

    // an accepted word is in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> q_valid)
        else $error("accepted word lost before the back end");

    // evictions are never final; every other result closes its request
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_EVICT) != m_tlast))
        else $error("tlast does not match result kind");

    // a clear reports no slot and no key
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_CLEAR) |-> (m_tdata == '0))
        else $error("clear result carries data");
`endif

endmodule

`default_nettype wire

[sv/tlct_front.sv]
// Front end: accepts input words, decodes the operation and queues commands.
// Depends on tlct_pkg.
`default_nettype none

module tlct_front
    import tlct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // tile_col, tile_row, frame_stamp, loadable, pad
    input  logic                 s_tuser,   // opcode
    output logic                 q_valid,
    input  logic                 q_ready,
    output cmd_t                 q_cmd
);

    cmd_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              cmd_in;
    logic              push;
    logic              pop;

    always_comb
    begin
        unique case (s_tuser)
            1'b0:    cmd_in.op = OP_LOOKUP;
            1'b1:    cmd_in.op = OP_CLEAR;
            default: cmd_in.op = OP_LOOKUP;
        endcase
        cmd_in.col      = s_tdata[15:0];
        cmd_in.row      = s_tdata[31:16];
        cmd_in.stamp    = s_tdata[63:32];
        cmd_in.loadable = s_tdata[64];
    end

    assign s_tready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_ready && q_valid;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

[sv/tlct_back.sv]
// Back end: tag store (key CAM, valid bits, stamp memory), LRU sequencer
// and output register. Depends on tlct_pkg.
`default_nettype none

module tlct_back
    import tlct_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CAP_BITS-1:0] capacity,
    input  logic                q_valid,
    output logic                q_ready,
    input  cmd_t                q_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output res_t                out_res
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    st_t                   state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [COORD_BITS-1:0] col_reg [ENTRIES];
    logic [COORD_BITS-1:0] row_reg [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
    logic [CNT_W-1:0]      occ_reg, occ_next;

    logic [STAMP_BITS-1:0] rd_stamp_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic                  have_min_reg;
    logic [IDX_W-1:0]      min_idx_reg;
    logic [STAMP_BITS-1:0] min_stamp_reg;

    res_t                  res_reg, res_next;
    logic                  out_valid_reg;

    logic [COORD_BITS-1:0] key_col, key_row;
    logic [STAMP_BITS-1:0] key_stamp;
    logic                  hit_any;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [CW-1:0]         cap_ext, cap_eff, occ_ext;
    logic                  full_now, full_after;
    logic                  out_free;

    logic                  emit, clr_all, set_v, clr_v, key_we, stamp_we;
    logic [IDX_W-1:0]      stamp_waddr;
    logic                  done, scan_start, scan_run, scan_issue, take_min;

    // keys sign-extended (or cut) to the stored width
    assign key_col   = COORD_BITS'($signed(cmd_reg.col));
    assign key_row   = COORD_BITS'($signed(cmd_reg.row));
    assign key_stamp = STAMP_BITS'(cmd_reg.stamp);

    // parallel tag match, lowest slot wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && col_reg[i] == key_col && row_reg[i] == key_row)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    // capacity clamped to 1..ENTRIES
    always_comb
    begin
        cap_ext = CW'(capacity);
        if (cap_ext == '0)
            cap_eff = CW'(1);
        else if (cap_ext > CW'(ENTRIES))
            cap_eff = CW'(ENTRIES);
        else
            cap_eff = cap_ext;
        occ_ext    = CW'(occ_reg);
        full_now   = (occ_ext >= cap_eff);
        full_after = ((occ_ext - CW'(1)) >= cap_eff);
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign scan_issue = scan_run && (scan_cnt_reg < CNT_W'(ENTRIES));
    assign take_min   = rd_vld_reg && valid_reg[rd_idx_reg] &&
                        (!have_min_reg || rd_stamp_reg < min_stamp_reg);

    // sequencer outputs
    always_comb
    begin
        emit        = 1'b0;
        clr_all     = 1'b0;
        set_v       = 1'b0;
        clr_v       = 1'b0;
        key_we      = 1'b0;
        stamp_we    = 1'b0;
        stamp_waddr = free_idx;
        done        = 1'b0;
        scan_start  = 1'b0;
        scan_run    = 1'b0;
        res_next    = '{kind: KIND_MISS, slot: '0, col: cmd_reg.col,
                        row: cmd_reg.row, last: 1'b1};
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    if (cmd_reg.op == OP_CLEAR)
                    begin
                        emit          = 1'b1;
                        clr_all       = 1'b1;
                        done          = 1'b1;
                        res_next.kind = KIND_CLEAR;
                        res_next.col  = '0;
                        res_next.row  = '0;
                    end
                    else if (hit_any)
                    begin
                        emit          = 1'b1;
                        stamp_we      = 1'b1;
                        stamp_waddr   = hit_idx;
                        done          = 1'b1;
                        res_next.kind = KIND_HIT;
                        res_next.slot = SLOT_W'(hit_idx);
                    end
                    else if (!cmd_reg.loadable)
                    begin
                        emit = 1'b1;
                        done = 1'b1;
                    end
                    else if (full_now)
                    begin
                        scan_start = 1'b1;
                    end
                    else
                    begin
                        emit          = 1'b1;
                        set_v         = 1'b1;
                        key_we        = 1'b1;
                        stamp_we      = 1'b1;
                        done          = 1'b1;
                        res_next.kind = KIND_FILL;
                        res_next.slot = SLOT_W'(free_idx);
                    end
                end
            end
            ST_SCAN:
            begin
                scan_run = 1'b1;
            end
            ST_EVICT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    clr_v         = 1'b1;
                    scan_start    = full_after;
                    res_next.kind = KIND_EVICT;
                    res_next.slot = SLOT_W'(min_idx_reg);
                    res_next.col  = KEY_W'(col_reg[min_idx_reg]);
                    res_next.row  = KEY_W'(row_reg[min_idx_reg]);
                    res_next.last = 1'b0;
                end
            end
            ST_FILL:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    set_v         = 1'b1;
                    key_we        = 1'b1;
                    stamp_we      = 1'b1;
                    done          = 1'b1;
                    res_next.kind = KIND_FILL;
                    res_next.slot = SLOT_W'(free_idx);
                end
            end
            default:
            begin
            end
        endcase
        q_ready = q_valid && (state_reg == ST_IDLE || done);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                if (scan_start)
                    state_next = ST_SCAN;
                else if (done)
                    state_next = q_valid ? ST_DECIDE : ST_IDLE;
            ST_SCAN:
                if (scan_cnt_reg == CNT_W'(ENTRIES))
                    state_next = ST_EVICT;
            ST_EVICT:
                if (out_free)
                    state_next = full_after ? ST_SCAN : ST_FILL;
            ST_FILL:
                if (done)
                    state_next = q_valid ? ST_DECIDE : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (clr_all)
        begin
            valid_next = '0;
            occ_next   = '0;
        end
        if (set_v)
        begin
            valid_next[free_idx] = 1'b1;
            occ_next             = occ_reg + CNT_W'(1);
        end
        if (clr_v)
        begin
            valid_next[min_idx_reg] = 1'b0;
            occ_next                = occ_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            have_min_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (scan_start)
            begin
                scan_cnt_reg <= '0;
                rd_vld_reg   <= 1'b0;
                have_min_reg <= 1'b0;
            end
            else if (scan_run)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                rd_vld_reg   <= scan_issue;
                if (take_min)
                    have_min_reg <= 1'b1;
            end
        end
    end

    // payload: command, keys, stamp memory, running minimum, result
    always_ff @(posedge clk)
    begin
        if (q_ready)
            cmd_reg <= q_cmd;
        if (key_we)
        begin
            col_reg[free_idx] <= key_col;
            row_reg[free_idx] <= key_row;
        end
        if (stamp_we)
            stamp_mem[stamp_waddr] <= key_stamp;
        if (scan_issue)
        begin
            rd_stamp_reg <= stamp_mem[scan_cnt_reg[IDX_W-1:0]];
            rd_idx_reg   <= scan_cnt_reg[IDX_W-1:0];
        end
        if (scan_run && take_min)
        begin
            min_idx_reg   <= rd_idx_reg;
            min_stamp_reg <= rd_stamp_reg;
        end
        if (emit)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire
